[rtl/vswb_pkg.sv]
// ----------------------------------------------------------------------------
// vswb_pkg
// Shared types, register map and helpers for the Verlet step with wall bounce
// ----------------------------------------------------------------------------
package vswb_pkg;

    // register reset values
    localparam logic [30:0] TIME_STEP_RST   = 31'd1092;
    localparam logic [30:0] INV_STEP_RST    = 31'd3932160;
    localparam logic [31:0] GRAVITY_RST     = 32'hFFF6_334C;   // -642228
    localparam logic [31:0] BOX_MIN_X_RST   = 32'd0;
    localparam logic [31:0] BOX_MAX_X_RST   = 32'd65536000;

    // register index, taken from paddr[4:2]
    localparam int           ADDR_WIDTH    = 5;
    localparam logic [2:0]   REG_TIME_STEP = 3'd0;
    localparam logic [2:0]   REG_INV_STEP  = 3'd1;
    localparam logic [2:0]   REG_GRAVITY   = 3'd2;
    localparam logic [2:0]   REG_BOX_MIN_X = 3'd3;
    localparam logic [2:0]   REG_BOX_MAX_X = 3'd4;

    // square root unit: 32 result bits, four per stage
    localparam int SQRT_STEPS_PER_STAGE = 4;
    localparam int SQRT_STAGES          = 32 / SQRT_STEPS_PER_STAGE;

    // front stages (x step, gravity, y step, velocity, walls, square sum); the depth adds root stages and output
    localparam int FRONT_STAGES = 6;
    localparam int PIPE_DEPTH   = FRONT_STAGES + SQRT_STAGES + 1;

    // particle state after the wall tests
    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] lx;
        logic [31:0] ly;
        logic [31:0] vx;
        logic [31:0] vy;
        logic        hit_left;
        logic        hit_floor;
        logic        hit_right;
    } wall_t;

    // partial square root
    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] root;
    } sqrt_t;

    // one digit step of the integer square root
    function automatic sqrt_t sqrt_iter(input sqrt_t s, input logic [5:0] sh);
        logic [63:0] b;
        logic [63:0] t;
        sqrt_t       o;
        b = 64'd1 << sh;
        t = s.root + b;
        if (s.rem >= t)
        begin
            o.rem  = s.rem - t;
            o.root = (s.root >> 1) + b;
        end
        else
        begin
            o.rem  = s.rem;
            o.root = s.root >> 1;
        end
        return o;
    endfunction

endpackage

[rtl/verlet_step_with_wall_bounce.sv]
// ----------------------------------------------------------------------------
// verlet_step_with_wall_bounce
// One Verlet step per particle, then left wall, floor and right wall bounce
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid, in_stall   | pos_x, pos_y, prev_x, prev_y, radius
//  out     | out_valid, out_stall | next_x, next_y, last_x, last_y, vel_x, vel_y
//  config  | apb write/read       | time_step, inverse_time_step, gravity, box
//
//  one item per cycle unless a stalled output holds the pipeline
//  15 register stages: 6 front stages, 8 square root stages (4 root bits each)
//  and the output register
//  reset clears valid bits and loads the register defaults
//  a stalled output freezes the whole pipeline; in_stall follows it
// ----------------------------------------------------------------------------
module verlet_step_with_wall_bounce
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [vswb_pkg::ADDR_WIDTH-1:0]    paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [31:0]                 pos_x,
    input  logic signed [31:0]                 pos_y,
    input  logic signed [31:0]                 prev_x,
    input  logic signed [31:0]                 prev_y,
    input  logic [30:0]                        radius,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [31:0]                 next_x,
    output logic signed [31:0]                 next_y,
    output logic signed [31:0]                 last_x,
    output logic signed [31:0]                 last_y,
    output logic signed [31:0]                 vel_x,
    output logic signed [31:0]                 vel_y
);

    localparam int LAST = vswb_pkg::PIPE_DEPTH - 1;
    localparam int NSQ  = vswb_pkg::SQRT_STAGES;

    // configuration registers
    logic [30:0] time_step_reg;
    logic [30:0] inv_step_reg;
    logic [31:0] gravity_reg;
    logic [31:0] box_min_x_reg;
    logic [31:0] box_max_x_reg;
    logic        cfg_write;
    logic [2:0]  cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg <= vswb_pkg::TIME_STEP_RST;
            inv_step_reg  <= vswb_pkg::INV_STEP_RST;
            gravity_reg   <= vswb_pkg::GRAVITY_RST;
            box_min_x_reg <= vswb_pkg::BOX_MIN_X_RST;
            box_max_x_reg <= vswb_pkg::BOX_MAX_X_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                vswb_pkg::REG_TIME_STEP: time_step_reg <= pwdata[30:0];
                vswb_pkg::REG_INV_STEP:  inv_step_reg  <= pwdata[30:0];
                vswb_pkg::REG_GRAVITY:   gravity_reg   <= pwdata;
                vswb_pkg::REG_BOX_MIN_X: box_min_x_reg <= pwdata;
                vswb_pkg::REG_BOX_MAX_X: box_max_x_reg <= pwdata;
                default: ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (cfg_index)
            vswb_pkg::REG_TIME_STEP: prdata = {1'b0, time_step_reg};
            vswb_pkg::REG_INV_STEP:  prdata = {1'b0, inv_step_reg};
            vswb_pkg::REG_GRAVITY:   prdata = gravity_reg;
            vswb_pkg::REG_BOX_MIN_X: prdata = box_min_x_reg;
            vswb_pkg::REG_BOX_MAX_X: prdata = box_max_x_reg;
            default:                 prdata = 32'd0;
        endcase
    end

    // pipeline advance and valid bits
    logic                      adv;
    logic                      in_accept;
    logic [LAST:0]             valid_reg;

    assign adv       = !(valid_reg[LAST] && out_stall);
    assign in_stall  = !adv;
    assign in_accept = in_valid && adv;
    assign out_valid = valid_reg[LAST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[LAST-1:0], in_accept};
        end
    end

    // stage 1: x step and dt squared
    logic [31:0] s1_nx_reg, s1_px_reg, s1_py_reg, s1_qy_reg;
    logic [30:0] s1_r_reg;
    logic [61:0] s1_dtsq_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_nx_reg   <= {pos_x[30:0], 1'b0} - prev_x;
            s1_px_reg   <= pos_x;
            s1_py_reg   <= pos_y;
            s1_qy_reg   <= prev_y;
            s1_r_reg    <= radius;
            s1_dtsq_reg <= 62'(time_step_reg) * 62'(time_step_reg);
        end
    end

    // stage 2: gravity term, floor(g * dt2 / 2^16)
    logic [31:0]        s2_nx_reg, s2_px_reg, s2_py_reg, s2_qy_reg, s2_acc_reg;
    logic [30:0]        s2_r_reg;
    logic signed [64:0] acc_prod;

    assign acc_prod = $signed(gravity_reg) * $signed({1'b0, s1_dtsq_reg[47:16]});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_nx_reg  <= s1_nx_reg;
            s2_px_reg  <= s1_px_reg;
            s2_py_reg  <= s1_py_reg;
            s2_qy_reg  <= s1_qy_reg;
            s2_r_reg   <= s1_r_reg;
            s2_acc_reg <= acc_prod[47:16];
        end
    end

    // stage 3: y step and displacement
    logic [31:0] s3_nx_reg, s3_ny_reg, s3_px_reg, s3_py_reg;
    logic [30:0] s3_r_reg;
    logic [32:0] s3_dx_reg, s3_dy_reg;
    logic [31:0] ny_c;

    assign ny_c = {s2_py_reg[30:0], 1'b0} - s2_qy_reg + s2_acc_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_nx_reg <= s2_nx_reg;
            s3_ny_reg <= ny_c;
            s3_px_reg <= s2_px_reg;
            s3_py_reg <= s2_py_reg;
            s3_r_reg  <= s2_r_reg;
            s3_dx_reg <= {s2_nx_reg[31], s2_nx_reg} - {s2_px_reg[31], s2_px_reg};
            s3_dy_reg <= {ny_c[31], ny_c} - {s2_py_reg[31], s2_py_reg};
        end
    end

    // stage 4: velocity, floor(d * inv / 2^16)
    logic [31:0]        s4_nx_reg, s4_ny_reg, s4_px_reg, s4_py_reg, s4_vx_reg, s4_vy_reg;
    logic [30:0]        s4_r_reg;
    logic signed [64:0] vx_prod, vy_prod;

    assign vx_prod = $signed(s3_dx_reg) * $signed({1'b0, inv_step_reg});
    assign vy_prod = $signed(s3_dy_reg) * $signed({1'b0, inv_step_reg});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_nx_reg <= s3_nx_reg;
            s4_ny_reg <= s3_ny_reg;
            s4_px_reg <= s3_px_reg;
            s4_py_reg <= s3_py_reg;
            s4_r_reg  <= s3_r_reg;
            s4_vx_reg <= vx_prod[47:16];
            s4_vy_reg <= vy_prod[47:16];
        end
    end

    // stage 5: wall tests and velocity squares
    logic [33:0]          left_d, right_d;
    logic [32:0]          floor_d;
    logic [31:0]          x1, x3, y2, lx1, ly1, lx2, ly2;
    logic                 hit_l, hit_f, hit_r;
    vswb_pkg::wall_t      w5;
    vswb_pkg::wall_t      s5_w_reg;
    logic signed [63:0]   sqx_c, sqy_c;
    logic [63:0]          s5_sqx_reg, s5_sqy_reg;

    always_comb
    begin
        left_d = {{2{s4_nx_reg[31]}}, s4_nx_reg} - {3'b0, s4_r_reg}
                 - {{2{box_min_x_reg[31]}}, box_min_x_reg};
        hit_l  = left_d[33];
        x1     = hit_l ? box_min_x_reg + {1'b0, s4_r_reg} : s4_nx_reg;
        lx1    = hit_l ? s4_nx_reg : s4_px_reg;
        ly1    = hit_l ? s4_ny_reg : s4_py_reg;

        floor_d = {s4_ny_reg[31], s4_ny_reg} - {2'b0, s4_r_reg};
        hit_f   = floor_d[32];
        y2      = hit_f ? {1'b0, s4_r_reg} : s4_ny_reg;
        lx2     = hit_f ? x1 : lx1;
        ly2     = hit_f ? s4_ny_reg : ly1;

        right_d = {{2{box_max_x_reg[31]}}, box_max_x_reg}
                  - ({{2{x1[31]}}, x1} + {3'b0, s4_r_reg});
        hit_r   = right_d[33];
        x3      = hit_r ? box_max_x_reg - {1'b0, s4_r_reg} : x1;

        w5.x         = x3;
        w5.y         = y2;
        w5.lx        = hit_r ? x1 : lx2;
        w5.ly        = hit_r ? y2 : ly2;
        w5.vx        = s4_vx_reg;
        w5.vy        = s4_vy_reg;
        w5.hit_left  = hit_l;
        w5.hit_floor = hit_f;
        w5.hit_right = hit_r;
    end

    assign sqx_c = $signed(s4_vx_reg) * $signed(s4_vx_reg);
    assign sqy_c = $signed(s4_vy_reg) * $signed(s4_vy_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_w_reg   <= w5;
            s5_sqx_reg <= sqx_c;
            s5_sqy_reg <= sqy_c;
        end
    end

    // stage 6: squared speed
    vswb_pkg::wall_t s6_w_reg;
    logic [63:0]     s6_sum_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_w_reg   <= s5_w_reg;
            s6_sum_reg <= s5_sqx_reg + s5_sqy_reg;
        end
    end

    // square root stages
    vswb_pkg::sqrt_t sq_reg  [NSQ];
    vswb_pkg::wall_t sqw_reg [NSQ];
    vswb_pkg::sqrt_t sq_in   [NSQ];
    vswb_pkg::sqrt_t sq_out  [NSQ];
    vswb_pkg::wall_t sqw_in  [NSQ];

    genvar g;
    generate
        for (g = 0; g < NSQ; g++)
        begin : g_sqrt
            if (g == 0)
            begin : g_first
                assign sq_in[g].rem  = s6_sum_reg;
                assign sq_in[g].root = 64'd0;
                assign sqw_in[g]     = s6_w_reg;
            end
            else
            begin : g_next
                assign sq_in[g]  = sq_reg[g-1];
                assign sqw_in[g] = sqw_reg[g-1];
            end

            always_comb
            begin
                vswb_pkg::sqrt_t st;
                st = sq_in[g];
                for (int i = 0; i < vswb_pkg::SQRT_STEPS_PER_STAGE; i++)
                begin
                    st = vswb_pkg::sqrt_iter(st,
                        6'(62 - 2 * (g * vswb_pkg::SQRT_STEPS_PER_STAGE + i)));
                end
                sq_out[g] = st;
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    sq_reg[g]  <= sq_out[g];
                    sqw_reg[g] <= sqw_in[g];
                end
            end
        end
    endgenerate

    // output stage: bounce velocity from speed
    vswb_pkg::wall_t wf;
    logic [31:0]     spd, spd_abs, s_right, s_floor;
    logic [31:0]     vx_c, vy_c;
    logic [31:0]     nx_out_reg, ny_out_reg, lx_out_reg, ly_out_reg, vx_out_reg, vy_out_reg;

    always_comb
    begin
        wf      = sqw_reg[NSQ-1];
        spd     = sq_reg[NSQ-1].root[31:0];
        spd_abs = spd[31] ? -spd : spd;
        s_right = (wf.hit_left || wf.hit_floor) ? spd_abs : spd;
        s_floor = wf.hit_left ? spd_abs : spd;
        if (wf.hit_right)
        begin
            vx_c = -s_right;
            vy_c = 32'd0;
        end
        else if (wf.hit_floor)
        begin
            vx_c = 32'd0;
            vy_c = s_floor;
        end
        else if (wf.hit_left)
        begin
            vx_c = spd;
            vy_c = 32'd0;
        end
        else
        begin
            vx_c = wf.vx;
            vy_c = wf.vy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nx_out_reg <= wf.x;
            ny_out_reg <= wf.y;
            lx_out_reg <= wf.lx;
            ly_out_reg <= wf.ly;
            vx_out_reg <= vx_c;
            vy_out_reg <= vy_c;
        end
    end

    assign next_x = nx_out_reg;
    assign next_y = ny_out_reg;
    assign last_x = lx_out_reg;
    assign last_y = ly_out_reg;
    assign vel_x  = vx_out_reg;
    assign vel_y  = vy_out_reg;

endmodule

[rtl/vswb_checker.sv]
// ----------------------------------------------------------------------------
// vswb_checker
// Port-level checks for the Verlet step block, bound to the top level
// ----------------------------------------------------------------------------
module vswb_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            psel,
    input logic                            penable,
    input logic                            pwrite,
    input logic [vswb_pkg::ADDR_WIDTH-1:0] paddr,
    input logic [31:0]                     pwdata,
    input logic [31:0]                     prdata,
    input logic                            pready,
    input logic                            in_stall,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [31:0]                     next_x,
    input logic [31:0]                     next_y,
    input logic [31:0]                     vel_x,
    input logic [31:0]                     vel_y
);

    // a stalled item stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out item dropped while stalled");

    // a stalled item keeps its next position and velocity
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable({next_x, next_y, vel_x, vel_y}))
        else $error("out payload changed while stalled");

    // input back-pressure only comes from a stalled result
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("in stalled without output stall");

    // a written left wall position reads back
    a_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && paddr[4:2] == vswb_pkg::REG_BOX_MIN_X)
        ##1 (psel && !pwrite && paddr[4:2] == vswb_pkg::REG_BOX_MIN_X)
        |-> prdata == $past(pwdata))
        else $error("register readback mismatch");

endmodule

bind verlet_step_with_wall_bounce vswb_checker u_vswb_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .next_x    (next_x),
    .next_y    (next_y),
    .vel_x     (vel_x),
    .vel_y     (vel_y)
);

[tb/verlet_step_with_wall_bounce_checker.sv]
// ----------------------------------------------------------------------------
// verlet_step_with_wall_bounce_checker
// Watches the register port and both item channels, predicts each particle
// update from a shadow copy of the registers and compares results in order
// ----------------------------------------------------------------------------
module verlet_step_with_wall_bounce_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [vswb_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]                     pwdata,
    input  logic                            pready,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic signed [31:0]              pos_x,
    input  logic signed [31:0]              pos_y,
    input  logic signed [31:0]              prev_x,
    input  logic signed [31:0]              prev_y,
    input  logic [30:0]                     radius,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic signed [31:0]              next_x,
    input  logic signed [31:0]              next_y,
    input  logic signed [31:0]              last_x,
    input  logic signed [31:0]              last_y,
    input  logic signed [31:0]              vel_x,
    input  logic signed [31:0]              vel_y,
    output int                              fail_count,
    output int                              pending
);

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] lx;
        logic [31:0] ly;
        logic [31:0] vx;
        logic [31:0] vy;
    } motion_t;

    // shadow registers
    longint   dt_q;
    longint   inv_q;
    longint   grav_q;
    longint   wall_lo;
    longint   wall_hi;
    motion_t  motion_q[$];

    // sign-extend the low 32 bits
    function automatic longint wrap32(longint v);
        logic signed [31:0] t;
        t = v[31:0];
        return longint'(t);
    endfunction

    // floor(a*b / 2^16) with an exact wide product
    function automatic longint mul_q16(longint a, longint b);
        logic signed [95:0] p;
        p = 96'(signed'(a)) * 96'(signed'(b));
        p = p >>> 16;
        return longint'(p[63:0]);
    endfunction

    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint speed_of(longint vx, longint vy);
        longint unsigned sq;
        sq = longint'(vx * vx);
        sq = sq + longint'(vy * vy);
        return wrap32(longint'(root64(sq)));
    endfunction

    function automatic motion_t advance_particle(longint px, longint py, longint qx,
                                                 longint qy, longint r);
        longint unsigned dt2;
        longint          acc;
        longint          x;
        longint          y;
        longint          vx;
        longint          vy;
        longint          lx;
        longint          ly;
        longint          s;
        motion_t         m;
        dt2 = ((dt_q * dt_q) >> 16) & 64'hFFFF_FFFF;
        acc = mul_q16(grav_q, longint'(dt2));
        x   = wrap32(2 * px - qx);
        y   = wrap32(2 * py - qy + acc);
        vx  = wrap32(mul_q16(x - px, inv_q));
        vy  = wrap32(mul_q16(y - py, inv_q));
        lx  = px;
        ly  = py;
        // left wall
        if (x - r - wall_lo < 0)
        begin
            s  = speed_of(vx, vy);
            lx = x;
            ly = y;
            x  = wrap32(wall_lo + r);
            vx = s;
            vy = 0;
        end
        // floor
        if (y - r < 0)
        begin
            s  = speed_of(vx, vy);
            lx = x;
            ly = y;
            y  = wrap32(r);
            vx = 0;
            vy = s;
        end
        // right wall
        if (wall_hi - (x + r) < 0)
        begin
            s  = speed_of(vx, vy);
            lx = x;
            ly = y;
            x  = wrap32(wall_hi - r);
            vx = wrap32(-s);
            vy = 0;
        end
        m.x  = x[31:0];
        m.y  = y[31:0];
        m.lx = lx[31:0];
        m.ly = ly[31:0];
        m.vx = vx[31:0];
        m.vy = vy[31:0];
        return m;
    endfunction

    task automatic report(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            if (fail_count < 10)
                $display("mismatch %s: expected %h actual %h", field, want, got);
            fail_count = fail_count + 1;
        end
    endtask

    initial
    begin
        fail_count = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dt_q    = longint'(vswb_pkg::TIME_STEP_RST);
            inv_q   = longint'(vswb_pkg::INV_STEP_RST);
            grav_q  = longint'(signed'(vswb_pkg::GRAVITY_RST));
            wall_lo = longint'(signed'(vswb_pkg::BOX_MIN_X_RST));
            wall_hi = longint'(signed'(vswb_pkg::BOX_MAX_X_RST));
            pending = motion_q.size();
        end
        else
        begin
            motion_t want;
            // register writes
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    vswb_pkg::REG_TIME_STEP: dt_q    = longint'(pwdata[30:0]);
                    vswb_pkg::REG_INV_STEP:  inv_q   = longint'(pwdata[30:0]);
                    vswb_pkg::REG_GRAVITY:   grav_q  = longint'(signed'(pwdata));
                    vswb_pkg::REG_BOX_MIN_X: wall_lo = longint'(signed'(pwdata));
                    vswb_pkg::REG_BOX_MAX_X: wall_hi = longint'(signed'(pwdata));
                    default: ;
                endcase
            end
            // accepted particle
            if (in_valid && !in_stall)
                motion_q.push_back(advance_particle(pos_x, pos_y, prev_x, prev_y,
                                                    longint'(radius)));
            // accepted result
            if (out_valid && !out_stall)
            begin
                if (motion_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("mismatch: result with no particle outstanding");
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = motion_q.pop_front();
                    report("next_x", want.x, next_x);
                    report("next_y", want.y, next_y);
                    report("last_x", want.lx, last_x);
                    report("last_y", want.ly, last_y);
                    report("vel_x", want.vx, vel_x);
                    report("vel_y", want.vy, vel_y);
                end
            end
            pending = motion_q.size();
        end
    end

endmodule

[tb/verlet_step_with_wall_bounce_tb.sv]
// ----------------------------------------------------------------------------
// verlet_step_with_wall_bounce_tb
// Streams particles through the block over several register settings, with
// random gaps and stalls on both sides and one long output hold-off; the
// checker predicts and compares every item
// ----------------------------------------------------------------------------
module verlet_step_with_wall_bounce_tb;

    localparam logic [2:0] REG_UNUSED = 3'd5;
    localparam int         IDLE_LIMIT = 3000;

    logic                            clk;
    logic                            rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [vswb_pkg::ADDR_WIDTH-1:0] paddr;
    logic [31:0]                     pwdata;
    logic [31:0]                     prdata;
    logic                            pready;
    logic                            in_valid;
    logic                            in_stall;
    logic signed [31:0]              pos_x;
    logic signed [31:0]              pos_y;
    logic signed [31:0]              prev_x;
    logic signed [31:0]              prev_y;
    logic [30:0]                     radius;
    logic                            out_valid;
    logic                            out_stall;
    logic signed [31:0]              next_x;
    logic signed [31:0]              next_y;
    logic signed [31:0]              last_x;
    logic signed [31:0]              last_y;
    logic signed [31:0]              vel_x;
    logic signed [31:0]              vel_y;
    int                              fail_count;
    int                              pending;
    int                              idle_cycles;
    bit                              calm;
    bit                              hold_req;
    longint                          box_lo;
    longint                          box_hi;

    verlet_step_with_wall_bounce DUT (.*);

    verlet_step_with_wall_bounce_checker checker_i (.*);

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // receiver side stalls
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                repeat (80)
                begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            out_stall <= calm ? 1'b0 : ($urandom_range(99) < 34);
        end
    end

    // watchdog on cycles with no accepted item
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_setting(logic [31:0] dt, logic [31:0] inv, logic [31:0] g,
                                logic [31:0] lo, logic [31:0] hi);
        reg_write(vswb_pkg::REG_TIME_STEP, dt);
        reg_write(vswb_pkg::REG_INV_STEP, inv);
        reg_write(vswb_pkg::REG_GRAVITY, g);
        reg_write(vswb_pkg::REG_BOX_MIN_X, lo);
        reg_write(vswb_pkg::REG_BOX_MAX_X, hi);
        box_lo = longint'(signed'(lo));
        box_hi = longint'(signed'(hi));
    endtask

    // offer one particle and wait until it is taken
    task automatic send_particle(logic [31:0] px, logic [31:0] py, logic [31:0] qx,
                                 logic [31:0] qy, logic [31:0] r);
        if (!calm)
        begin
            while ($urandom_range(99) < 34)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        pos_x    <= px;
        pos_y    <= py;
        prev_x   <= qx;
        prev_y   <= qy;
        radius   <= r[30:0];
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_random(int count);
        longint cx;
        longint cy;
        longint r;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 20)
                send_particle($urandom, $urandom, $urandom, $urandom, $urandom);
            else
            begin
                // a small particle moving near or inside the box
                r = $urandom_range(65536 * 4);
                if (box_lo < box_hi)
                    cx = box_lo + longint'($urandom) % (box_hi - box_lo + 1);
                else
                    cx = longint'(signed'($urandom));
                if ($urandom_range(3) == 0)
                    cx = ($urandom_range(1) ? box_lo : box_hi) +
                         longint'($urandom_range(65536 * 8)) - 65536 * 4;
                cy = longint'($urandom_range(65536 * 200)) - 65536 * 4;
                send_particle(cx[31:0], cy[31:0],
                              32'(cx + longint'($urandom_range(65536 * 8)) - 65536 * 4),
                              32'(cy + longint'($urandom_range(65536 * 8)) - 65536 * 4),
                              r[31:0]);
            end
        end
        in_valid <= 1'b0;
    endtask

    // let the checker see the last accepted item before polling
    task automatic drain;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (25) @(posedge clk);
    endtask

    initial
    begin
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        in_valid = 1'b0;
        pos_x    = '0;
        pos_y    = '0;
        prev_x   = '0;
        prev_y   = '0;
        radius   = '0;
        calm     = 1'b0;
        hold_req = 1'b0;
        box_lo   = 0;
        box_hi   = 65536000;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default setting; the unmapped index must be ignored
        load_setting(vswb_pkg::TIME_STEP_RST, vswb_pkg::INV_STEP_RST,
                     vswb_pkg::GRAVITY_RST, vswb_pkg::BOX_MIN_X_RST,
                     vswb_pkg::BOX_MAX_X_RST);
        reg_write(REG_UNUSED, 32'hDEAD_BEEF);

        // directed particles: field extremes, each wall, corners, overflow
        send_particle(0, 0, 0, 0, 0);
        send_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                      32'h7FFF_FFFF);
        send_particle(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        send_particle(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'h7FFF_FFFF);
        send_particle(32'd65536 * 5, 32'd65536 * 500, 32'd65536 * 8, 32'd65536 * 500,
                      32'd65536 * 4);
        send_particle(32'd65536 * 500, 32'd65536 * 2, 32'd65536 * 500,
                      32'd65536 * 4, 32'd65536 * 3);
        send_particle(32'd65536 * 998, 32'd65536 * 500, 32'd65536 * 995,
                      32'd65536 * 500, 32'd65536 * 3);
        send_particle(32'd65536, 32'd65536, 32'd65536 * 3, 32'd65536 * 3, 32'd65536 * 2);
        send_particle(32'd65536 * 999, 32'd65536, 32'd65536 * 997, 32'd65536 * 3,
                      32'd65536 * 2);
        send_particle(32'h4000_0000, 32'h4000_0000, 32'hC000_0000, 32'hC000_0000,
                      32'h0000_1000);
        send_particle(32'hC000_0000, 32'hC000_0000, 32'h4000_0000, 32'h4000_0000,
                      32'h4000_0000);
        send_particle(32'd65536 * 500, 0, 32'd65536 * 500, 0, 0);
        send_random(320);
        drain;

        // output held off while particles keep coming
        calm     = 1'b1;
        hold_req = 1'b1;
        send_random(120);
        drain;
        calm = 1'b0;

        // upper extremes, inverted box
        load_setting(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h8000_0000);
        send_particle(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF);
        send_random(300);
        drain;

        // lower extremes, widest box
        load_setting(0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_random(300);
        drain;

        // moderate box with unit step
        load_setting(32'd65536, 32'd65536, -32'sd655360, -32'sd3276800, 32'd3276800);
        send_random(300);
        drain;

        // random setting
        load_setting({1'b0, 31'($urandom)}, {1'b0, 31'($urandom)}, $urandom,
                     -32'sd65536 * $urandom_range(100), 32'd65536 * $urandom_range(1000));
        send_random(400);
        drain;

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[sim.f]
rtl/vswb_pkg.sv
rtl/verlet_step_with_wall_bounce.sv
rtl/vswb_checker.sv
tb/verlet_step_with_wall_bounce_checker.sv
tb/verlet_step_with_wall_bounce_tb.sv
